/* design/nfcp_pkg.sv */
// Shared types and constants of the response frame parser.
package nfcp_pkg;

  // Input request command codes
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Frame end status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_START  = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_BAD_ECHO   = 3'd3;
  localparam logic [2:0] ST_BAD_SUM    = 3'd4;
  localparam logic [2:0] ST_BAD_POST   = 3'd5;
  localparam logic [2:0] ST_TIMEOUT    = 3'd6;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Parser phase codes
  localparam logic [1:0] PH_DONE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_CMD = 1'b0;
  localparam logic CFG_TIMEOUT      = 1'b1;

  // Frame byte values
  localparam logic [7:0] TFI_CODE   = 8'hD5;
  localparam logic [7:0] START_CODE = 8'hFF;
  localparam logic [7:0] ZERO_CODE  = 8'h00;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // Header byte positions
  localparam logic [8:0] POS_PRE    = 9'd0;
  localparam logic [8:0] POS_START0 = 9'd1;
  localparam logic [8:0] POS_START1 = 9'd2;
  localparam logic [8:0] POS_LEN    = 9'd3;
  localparam logic [8:0] POS_LCS    = 9'd4;
  localparam logic [8:0] POS_TFI    = 9'd5;
  localparam logic [8:0] POS_BODY   = 9'd6;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic       last;
  } rsp_t;

endpackage

/* design/nfcp_ifs.sv */
// Valid/ready channel interfaces for the request and result streams.
interface nfcp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface nfcp_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output status,
                  output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input status,
                input last, output ready);
endinterface

/* design/nfcp_in_stage.sv */
// Input register: holds one accepted request until the parser takes it.
module nfcp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  nfcp_req_if.sink       in_req,
  input  logic           take,
  output logic           item_valid,
  output nfcp_pkg::req_t item
);

  logic           valid_r;
  logic           valid_nxt;
  nfcp_pkg::req_t item_r;
  logic           accept;

  // Free when empty or when the held request moves on this cycle
  assign in_req.ready = !valid_r || take;
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.command <= in_req.command;
      item_r.rx_byte <= in_req.rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* design/nfcp_frame_fsm.sv */
// Frame state, configuration registers and per-request decode.
module nfcp_frame_fsm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [nfcp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              fire,
  input  nfcp_pkg::req_t                    item,
  output logic                              res_valid,
  output nfcp_pkg::rsp_t                    res
);

  // Configuration
  logic [7:0]  exp_cmd_r;
  logic [15:0] timeout_r;

  // Frame state
  logic [1:0]  phase_r,   phase_nxt;
  logic [8:0]  pos_r,     pos_nxt;
  logic [7:0]  len_r,     len_nxt;
  logic [7:0]  sum_r,     sum_nxt;
  logic        sfault_r,  sfault_nxt;
  logic        hfault_r,  hfault_nxt;
  logic        efault_r,  efault_nxt;
  logic [15:0] ticks_r,   ticks_nxt;

  logic [7:0]  b;
  logic [8:0]  body_k;
  logic [8:0]  before_dcs;
  logic [7:0]  sum_add;
  logic [7:0]  echo_want;

  assign b          = item.rx_byte;
  assign body_k     = pos_r - nfcp_pkg::POS_BODY;
  assign before_dcs = {1'b0, len_r - 8'd1};
  assign sum_add    = sum_r + b;
  assign echo_want  = exp_cmd_r + 8'd1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= 8'd0;
      timeout_r <= nfcp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nfcp_pkg::CFG_EXPECTED_CMD: exp_cmd_r <= cfg_wdata[7:0];
        nfcp_pkg::CFG_TIMEOUT:      timeout_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Next state and result for the current request
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    sfault_nxt = sfault_r;
    hfault_nxt = hfault_r;
    efault_nxt = efault_r;
    ticks_nxt  = ticks_r;
    res_valid  = 1'b0;
    res        = '{kind: nfcp_pkg::KIND_STATUS, payload_byte: 8'd0,
                   status: nfcp_pkg::ST_OK, last: 1'b1};

    if (item.command == nfcp_pkg::CMD_RESTART) begin
      phase_nxt  = nfcp_pkg::PH_HEADER;
      pos_nxt    = 9'd0;
      len_nxt    = 8'd0;
      sum_nxt    = 8'd0;
      sfault_nxt = 1'b0;
      hfault_nxt = 1'b0;
      efault_nxt = 1'b0;
      ticks_nxt  = 16'd0;
    end else if (phase_r != nfcp_pkg::PH_DONE) begin
      unique case (phase_r) inside
        nfcp_pkg::PH_HEADER,
        nfcp_pkg::PH_BODY: begin
          if (item.command == nfcp_pkg::CMD_TICK) begin
            // Wait phase timer
            if (ticks_r >= timeout_r) begin
              res_valid  = 1'b1;
              res.status = nfcp_pkg::ST_TIMEOUT;
              phase_nxt  = nfcp_pkg::PH_DONE;
            end else begin
              ticks_nxt = ticks_r + 16'd1;
            end
          end else if (item.command == nfcp_pkg::CMD_BYTE) begin
            pos_nxt = pos_r + 9'd1;
            if (phase_r == nfcp_pkg::PH_HEADER) begin
              // Header checks, latched until the TFI byte
              case (pos_r) inside
                nfcp_pkg::POS_PRE, nfcp_pkg::POS_START0:
                  if (b != nfcp_pkg::ZERO_CODE) sfault_nxt = 1'b1;
                nfcp_pkg::POS_START1:
                  if (b != nfcp_pkg::START_CODE) sfault_nxt = 1'b1;
                nfcp_pkg::POS_LEN: begin
                  len_nxt = b;
                  if (b == 8'd0) hfault_nxt = 1'b1;
                end
                nfcp_pkg::POS_LCS:
                  if ((len_r + b) != 8'd0) hfault_nxt = 1'b1;
                default:
                  if (b != nfcp_pkg::TFI_CODE) hfault_nxt = 1'b1;
              endcase
              if (pos_r == nfcp_pkg::POS_TFI) begin
                if (sfault_nxt) begin
                  res_valid  = 1'b1;
                  res.status = nfcp_pkg::ST_BAD_START;
                  phase_nxt  = nfcp_pkg::PH_DONE;
                end else if (hfault_nxt) begin
                  res_valid  = 1'b1;
                  res.status = nfcp_pkg::ST_BAD_HEADER;
                  phase_nxt  = nfcp_pkg::PH_DONE;
                end else begin
                  sum_nxt    = nfcp_pkg::TFI_CODE;
                  efault_nxt = (len_r < 8'd2);
                  phase_nxt  = nfcp_pkg::PH_BODY;
                  ticks_nxt  = 16'd0;
                end
              end
            end else begin
              // Body: echo, data, DCS, then postamble
              if (body_k < before_dcs) begin
                sum_nxt = sum_add;
                if (body_k == 9'd0) begin
                  if (b != echo_want) efault_nxt = 1'b1;
                end else begin
                  res_valid = 1'b1;
                  res       = '{kind: nfcp_pkg::KIND_DATA, payload_byte: b,
                                status: nfcp_pkg::ST_OK, last: 1'b0};
                end
              end else if (body_k == before_dcs) begin
                sum_nxt = sum_add;
              end else begin
                res_valid = 1'b1;
                phase_nxt = nfcp_pkg::PH_DONE;
                if (efault_r) begin
                  res.status = nfcp_pkg::ST_BAD_ECHO;
                end else if (sum_r != 8'd0) begin
                  res.status = nfcp_pkg::ST_BAD_SUM;
                end else if (b != nfcp_pkg::ZERO_CODE) begin
                  res.status = nfcp_pkg::ST_BAD_POST;
                end else begin
                  res.status = nfcp_pkg::ST_OK;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= nfcp_pkg::PH_DONE;
      pos_r    <= 9'd0;
      len_r    <= 8'd0;
      sum_r    <= 8'd0;
      sfault_r <= 1'b0;
      hfault_r <= 1'b0;
      efault_r <= 1'b0;
      ticks_r  <= 16'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      sum_r    <= sum_nxt;
      sfault_r <= sfault_nxt;
      hfault_r <= hfault_nxt;
      efault_r <= efault_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

endmodule

/* design/nfcp_out_stage.sv */
// Result register: holds one result until the consumer takes it.
module nfcp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic           res_valid,
  input  nfcp_pkg::rsp_t res,
  output logic           can_load,
  nfcp_rsp_if.source     out_rsp
);

  logic           valid_r;
  logic           valid_nxt;
  nfcp_pkg::rsp_t data_r;

  // A new result may land when empty or when the held one leaves
  assign can_load = !valid_r || out_rsp.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && fire && res_valid) begin
      data_r <= res;
    end
  end

  assign out_rsp.valid        = valid_r;
  assign out_rsp.kind         = data_r.kind;
  assign out_rsp.payload_byte = data_r.payload_byte;
  assign out_rsp.status       = data_r.status;
  assign out_rsp.last         = data_r.last;

endmodule

/* design/nfc_response_frame_parser_core.sv */
// A held request's result (if any) is registered once the result register can load.
// Throughput: one request per cycle unless the output stalls; an input register and a
// result register decouple the two channels, so the input stalls only while both are
// full and the output is not ready. Each request is decoded by one compare/add stage
// between those registers. Reset (rst_n low, synchronous): no frame open, registers
// back to defaults (expected command 0, timeout 100 ticks), both stages empty.
module nfc_response_frame_parser_core (
  input  logic                            clk,
  input  logic                            rst_n,
  nfcp_req_if.sink                        in_req,
  nfcp_rsp_if.source                      out_rsp,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [nfcp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic           item_valid;
  nfcp_pkg::req_t item;
  logic           can_load;
  logic           fire;
  logic           res_valid;
  nfcp_pkg::rsp_t res;

  // Held request is decoded when the result register can take its result
  assign fire = item_valid && can_load;

  nfcp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  nfcp_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  nfcp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_rsp   (out_rsp)
  );

endmodule

/* design/nfcp_checker.sv */
// Port-level checks on the parser, bound to the top level.
module nfcp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_payload_byte,
  input logic [2:0] out_status,
  input logic       out_last
);

  // Data results are never the frame end and carry no status
  a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == nfcp_pkg::KIND_DATA) |-> !out_last &&
      (out_status == nfcp_pkg::ST_OK))
    else $error("data result with last or status set");

  // Status results close the frame with a known code and no data
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == nfcp_pkg::KIND_STATUS) |-> out_last &&
      (out_payload_byte == 8'd0) && (out_status <= nfcp_pkg::ST_TIMEOUT))
    else $error("malformed frame status result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_payload_byte) && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind nfc_response_frame_parser_core nfcp_checker u_nfcp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_kind         (out_rsp.kind),
  .out_payload_byte (out_rsp.payload_byte),
  .out_status       (out_rsp.status),
  .out_last         (out_rsp.last)
);

/* tb/sv/nfc_response_frame_parser_core_test.sv */
// Self-checking testbench for the response frame parser core.
`timescale 1ns / 1ps

module nfc_response_frame_parser_core_test;
  import nfcp_pkg::*;

  // Command code 3 is undefined; the parser must ignore it
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_GOAL  = 40;

  // Frame parser prediction plus the queue of results still owed by the block
  class frame_scoreboard;
    logic [7:0]  echo_cmd;
    logic [15:0] tick_limit;
    logic [1:0]  phase;
    logic [8:0]  pos;
    logic [7:0]  len;
    logic [7:0]  sum;
    bit          start_bad;
    bit          header_bad;
    bit          echo_bad;
    logic [15:0] ticks_waited;
    rsp_t        owed[$];
    int          mismatches;
    int          data_checked;
    int          status_checked;

    function new();
      echo_cmd       = 8'h00;
      tick_limit     = TIMEOUT_RESET;
      phase          = PH_DONE;
      pos            = '0;
      len            = '0;
      sum            = '0;
      start_bad      = 1'b0;
      header_bad     = 1'b0;
      echo_bad       = 1'b0;
      ticks_waited   = '0;
      mismatches     = 0;
      data_checked   = 0;
      status_checked = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void configure(logic idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_EXPECTED_CMD) echo_cmd = val[7:0];
      else tick_limit = val[15:0];
    endfunction

    function void owe_data(logic [7:0] b);
      rsp_t r;
      r.kind = KIND_DATA;
      r.payload_byte = b;
      r.status = ST_OK;
      r.last = 1'b0;
      owed = {owed, r};
    endfunction

    function void close_frame(logic [2:0] st);
      rsp_t r;
      r.kind = KIND_STATUS;
      r.payload_byte = 8'h00;
      r.status = st;
      r.last = 1'b1;
      owed = {owed, r};
      phase = PH_DONE;
    endfunction

    function void header_byte(logic [7:0] b);
      logic [7:0] lcs_sum;
      lcs_sum = len + b;
      case (pos)
        POS_PRE, POS_START0: if (b != ZERO_CODE) start_bad = 1'b1;
        POS_START1: if (b != START_CODE) start_bad = 1'b1;
        POS_LEN: begin
          len = b;
          if (b == 8'h00) header_bad = 1'b1;
        end
        POS_LCS: if (lcs_sum != 8'h00) header_bad = 1'b1;
        default: if (b != TFI_CODE) header_bad = 1'b1;
      endcase
      pos = pos + 9'd1;
      if (pos < POS_BODY) return;
      // faults reported on the sixth byte, bad start first
      if (start_bad) close_frame(ST_BAD_START);
      else if (header_bad) close_frame(ST_BAD_HEADER);
      else begin
        sum = TFI_CODE;
        if (len < 8'd2) echo_bad = 1'b1;
        phase = PH_BODY;
        ticks_waited = '0;
      end
    endfunction

    function void body_byte(logic [7:0] b);
      int k;
      int pre_dcs;
      logic [7:0] echo_want;
      k = int'(pos) - int'(POS_BODY);
      pre_dcs = int'(len) - 1;
      echo_want = echo_cmd + 8'd1;
      pos = pos + 9'd1;
      if (k < pre_dcs) begin
        sum = sum + b;
        if (k == 0) begin
          if (b != echo_want) echo_bad = 1'b1;
        end else begin
          owe_data(b);
        end
      end else if (k == pre_dcs) begin
        // checksum byte
        sum = sum + b;
      end else if (echo_bad) begin
        close_frame(ST_BAD_ECHO);
      end else if (sum != 8'h00) begin
        close_frame(ST_BAD_SUM);
      end else if (b != ZERO_CODE) begin
        close_frame(ST_BAD_POST);
      end else begin
        close_frame(ST_OK);
      end
    endfunction

    function void note_request(logic [1:0] cmd, logic [7:0] b);
      if (cmd == CMD_RESTART) begin
        phase = PH_HEADER;
        pos = '0;
        len = '0;
        sum = '0;
        start_bad = 1'b0;
        header_bad = 1'b0;
        echo_bad = 1'b0;
        ticks_waited = '0;
        return;
      end
      if (phase == PH_DONE || cmd == CMD_UNUSED) return;
      if (cmd == CMD_TICK) begin
        if (ticks_waited >= tick_limit) close_frame(ST_TIMEOUT);
        else ticks_waited = ticks_waited + 16'd1;
        return;
      end
      if (phase == PH_HEADER) header_byte(b);
      else body_byte(b);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        $error("result with nothing owed: kind %0d byte %0h status %0d last %0d",
               got.kind, got.payload_byte, got.status, got.last);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("status", 8'(want.status), 8'(got.status));
      compare_field("last", 8'(want.last), 8'(got.last));
      if (want.kind == KIND_STATUS) status_checked++;
      else data_checked++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nfcp_req_if req_ch ();
  nfcp_rsp_if rsp_ch ();

  frame_scoreboard chk = new();
  rsp_t            seen;
  int              send_idle_pct;
  int              recv_stall_pct;
  int unsigned     items_sent;
  int              cycle_count;
  int              settings_used;
  int              send_idle_by_mode[4] = '{0, 48, 0, 8};
  int              recv_stall_by_mode[4] = '{0, 0, 48, 8};
  logic [7:0]      seq[$];

  nfc_response_frame_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor both channels at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) chk.note_request(req_ch.command, req_ch.rx_byte);
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.kind = rsp_ch.kind;
        seen.payload_byte = rsp_ch.payload_byte;
        seen.status = rsp_ch.status;
        seen.last = rsp_ch.last;
        chk.check_result(seen);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, chk.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One request, with a random idle gap ahead of it; returns at the accepting edge
  task automatic send_req(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.rx_byte <= b;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$], input bit add_ticks);
    foreach (bytes[i]) begin
      if (add_ticks && $urandom_range(11) == 0) send_req(CMD_TICK, 8'($urandom));
      send_req(CMD_BYTE, bytes[i]);
    end
  endtask

  // Stop sending and let every owed result drain out
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the enable drops for a cycle before the next write
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.configure(idx, val);
    @(posedge clk);
  endtask

  // Random frames with random payload, most of them with one flaw injected
  task automatic random_frame();
    logic [7:0] fb[$];
    logic [7:0] len_b;
    logic [7:0] lcs_b;
    logic [7:0] echo_b;
    logic [7:0] run_sum;
    logic [7:0] d;
    logic [7:0] flip;
    int ndata;
    int flaw;
    int cut;
    int idx;
    ndata = ($urandom_range(11) == 0) ? $urandom_range(253) : $urandom_range(6);
    len_b = 8'(ndata + 2);
    lcs_b = 8'h00 - len_b;
    echo_b = chk.echo_cmd + 8'd1;
    run_sum = TFI_CODE + echo_b;
    flip = 8'd1 << $urandom_range(7);
    fb = {ZERO_CODE, ZERO_CODE, START_CODE, len_b, lcs_b, TFI_CODE, echo_b};
    repeat (ndata) begin
      d = 8'($urandom);
      run_sum = run_sum + d;
      fb = {fb, d};
    end
    d = 8'h00 - run_sum;
    fb = {fb, d};
    fb = {fb, ZERO_CODE};
    flaw = $urandom_range(16);
    case (flaw)
      7: begin
        idx = $urandom_range(2);
        fb[idx] = fb[idx] ^ flip;
      end
      8: begin
        fb[3] = 8'h00;
        fb[4] = 8'h00;
      end
      9: fb[4] = fb[4] ^ flip;
      10: fb[5] = fb[5] ^ flip;
      11: fb[6] = fb[6] ^ flip;
      12: fb[fb.size() - 2] = fb[fb.size() - 2] ^ flip;
      13: fb[fb.size() - 1] = fb[fb.size() - 1] ^ flip;
      14: begin
        // LEN one: no echo byte, the byte after TFI is the checksum
        d = 8'($urandom);
        fb = {ZERO_CODE, ZERO_CODE, START_CODE, 8'h01, 8'hFF, TFI_CODE, d, ZERO_CODE};
      end
      15, 16: begin
        cut = $urandom_range(fb.size() - 1);
        while (fb.size() > cut) void'(fb.pop_back());
      end
      default: ;
    endcase
    send_req(CMD_RESTART, 8'($urandom));
    send_bytes(fb, flaw != 16);
    // stalled frame: run the wait counter past its limit when that is short
    if (flaw == 16) begin
      if (chk.tick_limit <= 16'd20) repeat (int'(chk.tick_limit) + 1) send_req(CMD_TICK, 8'($urandom));
      else repeat (3) send_req(CMD_TICK, 8'($urandom));
    end
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 4)) send_req(2'($urandom_range(3)), 8'($urandom));
    end
  endtask

  task automatic random_phase(input logic [7:0] cmd_val, input logic [15:0] limit_val,
                              input int mode);
    int unsigned goal;
    settle();
    write_reg(CFG_EXPECTED_CMD, CFG_DATA_W'(cmd_val));
    write_reg(CFG_TIMEOUT, limit_val);
    settings_used++;
    send_idle_pct = send_idle_by_mode[mode];
    recv_stall_pct = recv_stall_by_mode[mode];
    goal = items_sent + PHASE_GOAL;
    while (items_sent < goal) random_frame();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_EXPECTED_CMD;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_BYTE;
    req_ch.rx_byte = 8'h00;
    rsp_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    cycle_count = 0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle items, undefined command, restart mid frame,
    // a clean frame with an all-ones data byte, and a LEN one frame
    send_req(CMD_TICK, 8'hFF);
    send_req(CMD_BYTE, 8'h00);
    send_req(CMD_UNUSED, 8'hA5);
    send_req(CMD_RESTART, 8'h00);
    seq = {ZERO_CODE, ZERO_CODE};
    send_bytes(seq, 1'b0);
    send_req(CMD_RESTART, 8'h00);
    // checksum: D5 + 01 + FF = D5, so DCS is 2B
    seq = {ZERO_CODE, ZERO_CODE, START_CODE, 8'h03, 8'hFD, TFI_CODE, 8'h01, 8'hFF, 8'h2B,
           ZERO_CODE};
    send_bytes(seq, 1'b0);
    send_req(CMD_RESTART, 8'h00);
    seq = {ZERO_CODE, ZERO_CODE, START_CODE, 8'h01, 8'hFF, TFI_CODE, 8'h2B, ZERO_CODE};
    send_bytes(seq, 1'b0);

    // Random frames under several register settings and pacing modes
    random_phase(8'hFF, 16'd1, 0);
    random_phase(8'h00, 16'd0, 1);
    random_phase(8'($urandom), 16'hFFFF, 2);
    random_phase(8'hD4, 16'd12, 3);
    random_phase(8'($urandom), 16'($urandom_range(1, 20)), 0);

    req_ch.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests under %0d register settings and four pacing modes.",
             items_sent, settings_used);
    $display("Checked %0d payload bytes and %0d frame status results.",
             chk.data_checked, chk.status_checked);
    if (chk.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
